@@ sv/btk_pkg.sv @@
// Package for the bounded top-k score queue.
// Holds sizes, the heap entry type, action codes and sequencer states; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package btk_pkg;
   localparam int MAX_ENTRIES = 16;
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int SCORE_W = 17;
   localparam int TAG_W = 16;
   localparam int ENTRY_W = SCORE_W + TAG_W;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [TAG_W-1:0] tag;
   } entry_type;

   typedef enum logic [1:0] {
      ACT_PUSH = 2'd0,
      ACT_POP = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SU_RD,
      ST_SU_CMP,
      ST_SD_RL,
      ST_SD_RR,
      ST_SD_CMP,
      ST_POP_SCAN,
      ST_POP_LAST,
      ST_POP_MOVE,
      ST_HP_NEXT,
      ST_HP_LOAD,
      ST_FIN_SCAN,
      ST_FIN_OUT
   } state_type;
endpackage
`default_nettype wire

@@ sv/bounded_top_k_score_queue_unit.sv @@
// Top level of the bounded top-k score queue: sequencer around a heap RAM.
// Depends on btk_pkg and btk_ram.
`timescale 1ns / 1ps
`default_nettype none
// The queue keeps the best-scoring entries, up to the capacity register, as a min-heap in
// one RAM with a registered read. Each transaction yields one response carrying the
// status after it. A push moves the new entry up the heap level by level, or, when the
// queue is full and the score beats the threshold, replaces the root and moves it down;
// it then scans all held entries for the best one and answers. A pop scans all entries,
// moves the last entry into the hole, rebuilds the heap by moving each parent node down
// and scans again. Capacity is written only while the queue is empty and idle.
module bounded_top_k_score_queue_unit
   import btk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // action[1:0], score[18:2], tag[34:19], zero fill
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // accepted[0], popped_valid[1], popped_score[18:2], popped_tag[34:19], empty_error[35],
   // entry_count[40:36], best_valid[41], best_score[58:42], best_tag[74:59],
   // admit_threshold[91:75], is_full[92], zero fill
   output logic [95:0]      rsp_tdata,
   input  wire logic        csr_tvalid,
   output logic             csr_tready,
   // capacity[4:0], zero fill
   input  wire logic [7:0]  csr_tdata
);
   state_type state_ff, state_in;
   action_type act_ff, act_in;
   logic [CW-1:0] n_ff, n_in, cap_ff, cap_in, idx_ff, idx_in;
   logic [AW-1:0] pos_ff, pos_in, hi_ff, hi_in, bslot_ff, bslot_in;
   logic [SCORE_W-1:0] thr_ff, thr_in, root_ff, root_in;
   entry_type cur_ff, cur_in, ldata_ff, ldata_in, best_ff, best_in;
   entry_type pop_ff, pop_in;
   logic acc_ff, acc_in, pv_ff, pv_in, err_ff, err_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;

   logic we;
   logic [AW-1:0] waddr, raddr;
   entry_type wdata, rd;
   logic [ENTRY_W-1:0] rdata_raw;

   logic [CW-1:0] l_idx;
   logic [CW:0] r_idx;
   logic r_ok;
   logic [AW-1:0] up_idx;
   entry_type req_entry;
   action_type req_act;
   logic [CW-1:0] csr_cap;
   entry_type sd_sel;
   logic [AW-1:0] sd_pos;
   logic scan_done;
   logic [SCORE_W-1:0] thr_new;
   entry_type best_out;

   btk_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_heap (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata_raw)
   );

   assign rd = entry_type'(rdata_raw);
   assign req_act = action_type'(req_tdata[1:0]);
   assign req_entry = '{score: req_tdata[18:2], tag: req_tdata[34:19]};
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign l_idx = {pos_ff, 1'b1};
   assign r_idx = {1'b0, pos_ff, 1'b0} + (CW+1)'(2);
   assign r_ok = r_idx < {1'b0, n_ff};
   assign up_idx = AW'((pos_ff - AW'(1)) >> 1);
   assign scan_done = (idx_ff == n_ff);

   always_comb begin
      csr_cap = csr_tdata[CW-1:0];
      if (csr_cap == '0) begin
         csr_cap = CW'(1);
      end else if (csr_cap > CW'(MAX_ENTRIES)) begin
         csr_cap = CW'(MAX_ENTRIES);
      end
   end

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      n_in = n_ff;
      cap_in = cap_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      hi_in = hi_ff;
      bslot_in = bslot_ff;
      thr_in = thr_ff;
      root_in = root_ff;
      cur_in = cur_ff;
      ldata_in = ldata_ff;
      best_in = best_ff;
      pop_in = pop_ff;
      acc_in = acc_ff;
      pv_in = pv_ff;
      err_in = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      we = 1'b0;
      waddr = pos_ff;
      wdata = cur_ff;
      raddr = idx_ff[AW-1:0];
      sd_sel = cur_ff;
      sd_pos = pos_ff;
      thr_new = '0;
      best_out = '0;

      if ((state_ff == ST_POP_SCAN || state_ff == ST_FIN_SCAN) && idx_ff != '0) begin
         if (idx_ff == CW'(1)) begin
            best_in = rd;
            bslot_in = '0;
            root_in = rd.score;
         end else if (rd.score > best_ff.score) begin
            best_in = rd;
            bslot_in = AW'(idx_ff - CW'(1));
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_tvalid && n_ff == '0) begin
               cap_in = csr_cap;
            end
            if (req_tvalid) begin
               act_in = req_act;
               acc_in = 1'b0;
               pv_in = 1'b0;
               err_in = 1'b0;
               pop_in = '0;
               idx_in = '0;
               cur_in = req_entry;
               state_in = ST_FIN_SCAN;
               case (req_act)
                  ACT_PUSH: begin
                     if (n_ff >= cap_ff) begin
                        if (n_ff != '0 && req_entry.score > thr_ff) begin
                           acc_in = 1'b1;
                           pos_in = '0;
                           state_in = ST_SD_RL;
                        end
                     end else if (n_ff < CW'(MAX_ENTRIES)) begin
                        acc_in = 1'b1;
                        pos_in = n_ff[AW-1:0];
                        n_in = n_ff + CW'(1);
                        state_in = ST_SU_RD;
                     end
                  end
                  ACT_POP: begin
                     if (n_ff == '0) begin
                        err_in = 1'b1;
                     end else begin
                        state_in = ST_POP_SCAN;
                     end
                  end
                  ACT_CLEAR: begin
                     n_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SU_RD: begin
            if (pos_ff == '0) begin
               we = 1'b1;
               state_in = ST_FIN_SCAN;
            end else begin
               raddr = up_idx;
               state_in = ST_SU_CMP;
            end
         end
         ST_SU_CMP: begin
            we = 1'b1;
            if (cur_ff.score < rd.score) begin
               wdata = rd;
               pos_in = up_idx;
               state_in = ST_SU_RD;
            end else begin
               state_in = ST_FIN_SCAN;
            end
         end
         ST_SD_RL: begin
            if (l_idx < n_ff) begin
               raddr = l_idx[AW-1:0];
               state_in = ST_SD_RR;
            end else begin
               we = 1'b1;
               state_in = (act_ff == ACT_POP) ? ST_HP_NEXT : ST_FIN_SCAN;
            end
         end
         ST_SD_RR: begin
            ldata_in = rd;
            raddr = r_idx[AW-1:0];
            state_in = ST_SD_CMP;
         end
         ST_SD_CMP: begin
            if (ldata_ff.score < cur_ff.score) begin
               sd_sel = ldata_ff;
               sd_pos = l_idx[AW-1:0];
            end
            if (r_ok && rd.score < sd_sel.score) begin
               sd_sel = rd;
               sd_pos = r_idx[AW-1:0];
            end
            we = 1'b1;
            if (sd_pos == pos_ff) begin
               state_in = (act_ff == ACT_POP) ? ST_HP_NEXT : ST_FIN_SCAN;
            end else begin
               wdata = sd_sel;
               pos_in = sd_pos;
               state_in = ST_SD_RL;
            end
         end
         ST_POP_SCAN: begin
            if (scan_done) begin
               state_in = ST_POP_LAST;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_POP_LAST: begin
            raddr = AW'(n_ff - CW'(1));
            state_in = ST_POP_MOVE;
         end
         ST_POP_MOVE: begin
            we = 1'b1;
            waddr = bslot_ff;
            wdata = rd;
            pv_in = 1'b1;
            pop_in = best_ff;
            n_in = n_ff - CW'(1);
            hi_in = AW'((n_ff - CW'(1)) >> 1);
            state_in = ST_HP_NEXT;
         end
         ST_HP_NEXT: begin
            if (hi_ff == '0) begin
               idx_in = '0;
               state_in = ST_FIN_SCAN;
            end else begin
               pos_in = hi_ff - AW'(1);
               raddr = hi_ff - AW'(1);
               hi_in = hi_ff - AW'(1);
               state_in = ST_HP_LOAD;
            end
         end
         ST_HP_LOAD: begin
            cur_in = rd;
            state_in = ST_SD_RL;
         end
         ST_FIN_SCAN: begin
            if (scan_done) begin
               state_in = ST_FIN_OUT;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_FIN_OUT: begin
            if (n_ff != '0 && n_ff >= cap_ff) begin
               thr_new = root_ff;
            end
            if (n_ff != '0) begin
               best_out = best_ff;
            end
            if (!rsp_valid_ff || rsp_tready) begin
               thr_in = thr_new;
               rsp_valid_in = 1'b1;
               rsp_data_in = {3'b000, (n_ff == cap_ff), thr_new, best_out.tag,
                              best_out.score, (n_ff != '0), n_ff, err_ff, pop_ff.tag,
                              pop_ff.score, pv_ff, acc_ff};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (state_ff == ST_SU_RD || state_ff == ST_SU_CMP || state_ff == ST_SD_RL ||
          state_ff == ST_SD_CMP || state_ff == ST_HP_NEXT) begin
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff <= '0;
         cap_ff <= CW'(MAX_ENTRIES);
         thr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         cap_ff <= cap_in;
         thr_ff <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      hi_ff <= hi_in;
      bslot_ff <= bslot_in;
      root_ff <= root_in;
      cur_ff <= cur_in;
      ldata_ff <= ldata_in;
      best_ff <= best_in;
      pop_ff <= pop_in;
      acc_ff <= acc_in;
      pv_ff <= pv_in;
      err_ff <= err_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule
`default_nettype wire

@@ sv/btk_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the heap storage.
`timescale 1ns / 1ps
`default_nettype none
module btk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire
